// ===== rtl/core/xs128_pkg.sv =====
`timescale 1ns / 1ps

package xs128_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumGen = 4;
  localparam int unsigned GenIdxW = $clog2(NumGen);

  localparam logic [WordW-1:0] SEED_GAMMA = 32'h9E37_79B9;
  localparam logic [WordW-1:0] MIX_MUL_A  = 32'h85EB_CA6B;
  localparam logic [WordW-1:0] MIX_MUL_B  = 32'hC2B2_AE35;
  localparam logic [WordW-1:0] DRAW_MUL_5 = 32'd5;
  localparam logic [WordW-1:0] DRAW_MUL_9 = 32'd9;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW_MUL5,
    ST_DRAW_MUL9,
    ST_DRAW_OUT,
    ST_SEED_MIXA,
    ST_SEED_MIXB,
    ST_SEED_STORE
  } xs_state_t;

  typedef struct packed {
    logic             en;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } mul_req_t;

  function automatic logic [WordW-1:0] rotl7(input logic [WordW-1:0] v);
    return {v[WordW-8:0], v[WordW-1:WordW-7]};
  endfunction

  function automatic logic [WordW-1:0] rotl11(input logic [WordW-1:0] v);
    return {v[WordW-12:0], v[WordW-1:WordW-11]};
  endfunction

endpackage

// ===== rtl/core/xs128_mul.sv =====
`timescale 1ns / 1ps

module xs128_mul (
  input  logic                            clk,
  input  xs128_pkg::mul_req_t             req,
  output logic [xs128_pkg::WordW-1:0]     prod
);

  logic [xs128_pkg::WordW-1:0] prod_r;

  // keep only the low word of the product
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= xs128_pkg::WordW'(req.a * req.b);
    end
  end

  assign prod = prod_r;

endmodule

// ===== rtl/core/xoshiro128ss_prng_with_seeding.sv =====
`timescale 1ns / 1ps

// xoshiro128** generator with a SplitMix32-style seed loader. An input word
// with in_tuser = 1 reseeds the four state words from in_tdata and gives no
// output; an input word with in_tuser = 0 draws one 32-bit word, delivered on
// out_tdata. All multiplications go through one registered 32x32 multiplier
// under a small sequencer, one product per cycle. A draw steps through
// DRAW_MUL5, DRAW_MUL9 and DRAW_OUT until in_tready returns (DRAW_OUT holds
// while a previous output word still waits); a reseed steps through SEED_MIXA,
// SEED_MIXB and SEED_STORE once per state word. An output word waits in its
// own register, so the next input word is taken while it is pending. After
// reset the state is all zero and draws return zero until the first reseed.
module xoshiro128ss_prng_with_seeding (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed_value
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] random_word
);

  localparam int unsigned W = xs128_pkg::WordW;

  xs128_pkg::xs_state_t state_r, state_nxt;

  logic [W-1:0]                   gen_r   [xs128_pkg::NumGen];
  logic [W-1:0]                   gen_nxt [xs128_pkg::NumGen];
  logic [W-1:0]                   run_r, run_nxt;
  logic [xs128_pkg::GenIdxW-1:0]  widx_r, widx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [W-1:0]                   out_data_r, out_data_nxt;

  xs128_pkg::mul_req_t mul_req;
  logic [W-1:0]        mul_q;
  logic [W-1:0]        run_sum;
  logic                in_fire;
  logic                out_free;

  xs128_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_q)
  );

  assign in_tready  = (state_r == xs128_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign run_sum    = run_r + xs128_pkg::SEED_GAMMA;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    widx_nxt      = widx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    for (int i = 0; i < xs128_pkg::NumGen; i++) begin
      gen_nxt[i] = gen_r[i];
    end
    mul_req = '{en: 1'b0, a: '0, b: '0};

    case (state_r)
      xs128_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == xs128_pkg::CMD_SEED) begin
            run_nxt   = in_tdata;
            widx_nxt  = '0;
            state_nxt = xs128_pkg::ST_SEED_MIXA;
          end else begin
            state_nxt = xs128_pkg::ST_DRAW_MUL5;
          end
        end
      end

      xs128_pkg::ST_DRAW_MUL5: begin
        // sample s1 into the multiplier and advance the state together
        mul_req    = '{en: 1'b1, a: gen_r[1], b: xs128_pkg::DRAW_MUL_5};
        gen_nxt[2] = gen_r[2] ^ gen_r[0] ^ {gen_r[1][W-10:0], 9'd0};
        gen_nxt[1] = gen_r[1] ^ gen_r[2] ^ gen_r[0];
        gen_nxt[0] = gen_r[0] ^ gen_r[3] ^ gen_r[1];
        gen_nxt[3] = xs128_pkg::rotl11(gen_r[3] ^ gen_r[1]);
        state_nxt  = xs128_pkg::ST_DRAW_MUL9;
      end

      xs128_pkg::ST_DRAW_MUL9: begin
        mul_req   = '{en: 1'b1, a: xs128_pkg::rotl7(mul_q), b: xs128_pkg::DRAW_MUL_9};
        state_nxt = xs128_pkg::ST_DRAW_OUT;
      end

      xs128_pkg::ST_DRAW_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mul_q;
          state_nxt     = xs128_pkg::ST_IDLE;
        end
      end

      xs128_pkg::ST_SEED_MIXA: begin
        run_nxt   = run_sum;
        mul_req   = '{en: 1'b1, a: run_sum ^ (run_sum >> 15), b: xs128_pkg::MIX_MUL_A};
        state_nxt = xs128_pkg::ST_SEED_MIXB;
      end

      xs128_pkg::ST_SEED_MIXB: begin
        mul_req   = '{en: 1'b1, a: mul_q ^ (mul_q >> 13), b: xs128_pkg::MIX_MUL_B};
        state_nxt = xs128_pkg::ST_SEED_STORE;
      end

      xs128_pkg::ST_SEED_STORE: begin
        gen_nxt[widx_r] = mul_q ^ (mul_q >> 16);
        widx_nxt        = widx_r + 1'b1;
        if (widx_r == xs128_pkg::GenIdxW'(xs128_pkg::NumGen - 1)) begin
          state_nxt = xs128_pkg::ST_IDLE;
        end else begin
          state_nxt = xs128_pkg::ST_SEED_MIXA;
        end
      end

      default: begin
        state_nxt = xs128_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xs128_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      widx_r      <= '0;
      for (int i = 0; i < xs128_pkg::NumGen; i++) begin
        gen_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      widx_r      <= widx_nxt;
      for (int i = 0; i < xs128_pkg::NumGen; i++) begin
        gen_r[i] <= gen_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    run_r      <= run_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
